/* rtl/alcar_pkg.sv */
// Package for the associative line cache: op codes and sequencer states.
// No dependencies.
package alcar_pkg;
	typedef enum logic [2:0] {
		OP_READ  = 3'd0,
		OP_WRITE = 3'd1,
		OP_TICK  = 3'd2,
		OP_FLUSH = 3'd3,
		OP_MREAD = 3'd4,
		OP_MLOAD = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_WB_RD,
		ST_WB_WR,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_ACCESS,
		ST_ACC_DONE,
		ST_MREAD,
		ST_FLUSH_SEL,
		ST_CLEAR,
		ST_OUT
	} state_t;
endpackage

/* rtl/alcar_ram.sv */
// Generic simple dual-port synchronous RAM (one write port, one read port) with a registered read.
// No dependencies.
module alcar_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/assoc_line_cache_age_replace_unit.sv */
// Top level of the associative line cache with age-based replacement.
// Uses alcar_pkg and alcar_ram (line data store and backing store).
// A read or write that misses first writes back the victim line if it is valid, then fills the line;
// a flush writes back every valid dirty line to the backing store.
// One item at a time: the next item is taken only after the result has been accepted.
// Reset clears tags, valid, dirty and ages at once; a pass then zeroes both RAMs, one word a cycle,
// before the first item is taken.
module assoc_line_cache_age_replace_unit #(
	parameter int LINES          = 5,
	parameter int WORDS_PER_LINE = 10,
	parameter int MEM_WORDS      = 128,
	parameter int WORD_BITS      = 16,
	parameter int AGE_BITS       = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           op,
	input  logic [6:0]           addr,
	input  logic [15:0]          wdata,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          rdata,
	output logic                 miss
);
	localparam int LB     = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int OB     = $clog2(WORDS_PER_LINE);
	localparam int CDEPTH = LINES * WORDS_PER_LINE;
	localparam int CB     = $clog2(CDEPTH);
	localparam int MB     = $clog2(MEM_WORDS);
	localparam int ROWB   = 8;
	localparam int EB     = ((MB > CB) ? MB : CB) + 1;
	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

	alcar_pkg::state_t state_q, state_d;

	logic [2:0]          op_q;
	logic [6:0]          addr_q;
	logic [WORD_BITS-1:0] wdata_q;
	logic [ROWB-1:0]     row_q;
	logic [OB-1:0]       off_q;
	logic [LB-1:0]       line_q;
	logic [OB:0]         w_q;
	logic [EB-1:0]       clr_q;
	logic                miss_q;
	logic [15:0]         rdata_q;

	logic [ROWB-1:0]     tag_q   [LINES];
	logic                valid_q [LINES];
	logic                dirty_q [LINES];
	logic [AGE_BITS-1:0] age_q   [LINES];

	// RAM ports
	logic                 c_we, m_we;
	logic [CB-1:0]        c_waddr, c_raddr;
	logic [MB-1:0]        m_waddr, m_raddr;
	logic [WORD_BITS-1:0] c_wdata, m_wdata, c_rdata, m_rdata;

	alcar_ram #(.WIDTH(WORD_BITS), .DEPTH(CDEPTH)) u_lines (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata));
	alcar_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_WORDS)) u_mem (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata));

	// row and word offset of the incoming address by constant compares
	logic [ROWB-1:0] in_row;
	logic [OB-1:0]   in_off;
	always_comb begin
		in_row = '0;
		for (int r = 1; r * WORDS_PER_LINE < 128; r++)
			if (32'(addr) >= r * WORDS_PER_LINE) in_row = ROWB'(r);
		in_off = OB'(32'(addr) - 32'(in_row) * WORDS_PER_LINE);
	end

	// lookup and victim search over the small tag array
	logic          hit;
	logic [LB-1:0] hit_line, vic_line, fl_line;
	logic          fl_any;
	always_comb begin
		logic found_inv;
		logic [AGE_BITS-1:0] best;
		hit = 1'b0;
		hit_line = '0;
		found_inv = 1'b0;
		vic_line = '0;
		best = age_q[0];
		fl_any = 1'b0;
		fl_line = '0;
		for (int k = 0; k < LINES; k++) begin
			if (!hit && valid_q[k] && tag_q[k] == row_q) begin
				hit = 1'b1;
				hit_line = LB'(k);
			end
			if (!fl_any && valid_q[k] && dirty_q[k]) begin
				fl_any = 1'b1;
				fl_line = LB'(k);
			end
		end
		for (int k = 0; k < LINES; k++)
			if (!found_inv && !valid_q[k]) begin
				found_inv = 1'b1;
				vic_line = LB'(k);
			end
		if (!found_inv)
			for (int k = 1; k < LINES; k++)
				if (age_q[k] > best) begin
					best = age_q[k];
					vic_line = LB'(k);
				end
	end

	// word addresses
	logic [EB+ROWB-1:0] wb_addr, fill_addr;
	logic [CB+LB-1:0]   cline_addr, cacc_addr;
	assign wb_addr    = (EB+ROWB)'(tag_q[line_q]) * (EB+ROWB)'(WORDS_PER_LINE)
		+ (EB+ROWB)'(w_q);
	assign fill_addr  = (EB+ROWB)'(row_q) * (EB+ROWB)'(WORDS_PER_LINE)
		+ (EB+ROWB)'(w_q);
	assign cline_addr = (CB+LB)'(line_q) * (CB+LB)'(WORDS_PER_LINE) + (CB+LB)'(w_q);
	assign cacc_addr  = (CB+LB)'(line_q) * (CB+LB)'(WORDS_PER_LINE) + (CB+LB)'(off_q);

	logic wb_in, fill_in, addr_in;
	assign wb_in   = wb_addr < (EB+ROWB)'(MEM_WORDS);
	assign fill_in = fill_addr < (EB+ROWB)'(MEM_WORDS);
	assign addr_in = 32'(addr_q) < MEM_WORDS;

	logic last_w;
	assign last_w = w_q == (OB+1)'(WORDS_PER_LINE - 1);

	assign in_ready  = state_q == alcar_pkg::ST_IDLE;
	assign out_valid = state_q == alcar_pkg::ST_OUT;
	assign rdata     = rdata_q;
	assign miss      = miss_q;

	always_comb begin
		state_d = state_q;
		c_we = 1'b0;
		m_we = 1'b0;
		c_waddr = cline_addr[CB-1:0];
		c_raddr = cline_addr[CB-1:0];
		c_wdata = m_rdata;
		m_waddr = wb_addr[MB-1:0];
		m_raddr = fill_addr[MB-1:0];
		m_wdata = c_rdata;
		case (state_q)
			alcar_pkg::ST_CLEAR: begin
				c_we = 32'(clr_q) < CDEPTH;
				m_we = 1'b1;
				c_waddr = clr_q[CB-1:0];
				m_waddr = clr_q[MB-1:0];
				c_wdata = '0;
				m_wdata = '0;
				if (32'(clr_q) == MEM_WORDS - 1 || 32'(clr_q) == CDEPTH - 1)
					if (32'(clr_q) >= MEM_WORDS - 1 && 32'(clr_q) >= CDEPTH - 1)
						state_d = alcar_pkg::ST_IDLE;
			end
			alcar_pkg::ST_IDLE: if (in_valid) state_d = alcar_pkg::ST_LOOK;
			alcar_pkg::ST_LOOK: begin
				case (op_q)
					alcar_pkg::OP_READ, alcar_pkg::OP_WRITE:
						state_d = hit ? alcar_pkg::ST_ACCESS :
							(valid_q[vic_line] ? alcar_pkg::ST_WB_RD :
							alcar_pkg::ST_FILL_RD);
					alcar_pkg::OP_FLUSH:
						state_d = alcar_pkg::ST_FLUSH_SEL;
					alcar_pkg::OP_MREAD: begin
						m_raddr = MB'(addr_q);
						state_d = alcar_pkg::ST_MREAD;
					end
					alcar_pkg::OP_MLOAD: begin
						m_we = addr_in;
						m_waddr = MB'(addr_q);
						m_wdata = wdata_q;
						state_d = alcar_pkg::ST_OUT;
					end
					default: state_d = alcar_pkg::ST_OUT;
				endcase
			end
			alcar_pkg::ST_FLUSH_SEL:
				state_d = fl_any ? alcar_pkg::ST_WB_RD : alcar_pkg::ST_OUT;
			alcar_pkg::ST_WB_RD: state_d = alcar_pkg::ST_WB_WR;
			alcar_pkg::ST_WB_WR: begin
				m_we = wb_in;
				if (last_w)
					state_d = (op_q == alcar_pkg::OP_FLUSH) ? alcar_pkg::ST_FLUSH_SEL
						: alcar_pkg::ST_FILL_RD;
				else
					state_d = alcar_pkg::ST_WB_RD;
			end
			alcar_pkg::ST_FILL_RD: state_d = alcar_pkg::ST_FILL_WR;
			alcar_pkg::ST_FILL_WR: begin
				c_we = 1'b1;
				c_wdata = fill_in ? m_rdata : '0;
				state_d = last_w ? alcar_pkg::ST_ACCESS : alcar_pkg::ST_FILL_RD;
			end
			alcar_pkg::ST_ACCESS: begin
				c_raddr = cacc_addr[CB-1:0];
				c_waddr = cacc_addr[CB-1:0];
				c_wdata = wdata_q;
				c_we = op_q == alcar_pkg::OP_WRITE;
				state_d = alcar_pkg::ST_ACC_DONE;
			end
			alcar_pkg::ST_ACC_DONE: state_d = alcar_pkg::ST_OUT;
			alcar_pkg::ST_MREAD: state_d = alcar_pkg::ST_OUT;
			alcar_pkg::ST_OUT: if (out_ready) state_d = alcar_pkg::ST_IDLE;
			default: state_d = alcar_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alcar_pkg::ST_CLEAR;
			clr_q <= '0;
			w_q <= '0;
			miss_q <= 1'b0;
			for (int k = 0; k < LINES; k++) begin
				tag_q[k] <= '0;
				valid_q[k] <= 1'b0;
				dirty_q[k] <= 1'b0;
				age_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				alcar_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				alcar_pkg::ST_IDLE: if (in_valid) begin
					op_q <= op;
					addr_q <= addr;
					wdata_q <= WORD_BITS'(wdata);
					row_q <= in_row;
					off_q <= in_off;
					miss_q <= 1'b0;
					rdata_q <= '0;
					w_q <= '0;
				end
				alcar_pkg::ST_LOOK: begin
					if (op_q == alcar_pkg::OP_TICK)
						for (int k = 0; k < LINES; k++)
							if (age_q[k] != AGE_MAX) age_q[k] <= age_q[k] + 1'b1;
					if (op_q == alcar_pkg::OP_READ || op_q == alcar_pkg::OP_WRITE) begin
						line_q <= hit ? hit_line : vic_line;
						miss_q <= !hit;
					end
				end
				alcar_pkg::ST_FLUSH_SEL: begin
					line_q <= fl_line;
					w_q <= '0;
				end
				alcar_pkg::ST_WB_WR: begin
					if (last_w) begin
						w_q <= '0;
						if (op_q == alcar_pkg::OP_FLUSH) dirty_q[line_q] <= 1'b0;
					end else
						w_q <= w_q + 1'b1;
				end
				alcar_pkg::ST_FILL_WR: begin
					if (last_w) begin
						w_q <= '0;
						tag_q[line_q] <= row_q;
						valid_q[line_q] <= 1'b1;
						dirty_q[line_q] <= 1'b0;
					end else
						w_q <= w_q + 1'b1;
				end
				alcar_pkg::ST_ACCESS: begin
					age_q[line_q] <= '0;
					if (op_q == alcar_pkg::OP_WRITE) dirty_q[line_q] <= 1'b1;
				end
				alcar_pkg::ST_ACC_DONE:
					if (op_q == alcar_pkg::OP_READ) rdata_q <= 16'(c_rdata);
				alcar_pkg::ST_MREAD:
					rdata_q <= addr_in ? 16'(m_rdata) : '0;
				default: ;
			endcase
		end
	end
endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the associative line cache with age-based replacement.
// Depends on alcar_pkg and assoc_line_cache_age_replace_unit; predicts each result in-line.
`timescale 1ns / 100ps

module tb_top;
	localparam int NLINES = 5;
	localparam int NWORDS = 10;
	localparam int NMEM   = 128;
	localparam logic [15:0] AGE_TOP = 16'hFFFF;
	localparam logic [2:0] OP_NONE6 = 3'd6;
	localparam logic [2:0] OP_NONE7 = 3'd7;

	typedef struct packed {
		logic [15:0] rdata;
		logic        miss;
	} cache_rsp_t;

	typedef struct {
		logic [2:0]  op;
		logic [6:0]  addr;
		logic [15:0] wdata;
		bit          known;
		cache_rsp_t  rsp;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  op = '0;
	logic [6:0]  addr = '0;
	logic [15:0] wdata = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] rdata;
	logic        miss;

	logic [15:0] mdl_words [NLINES][NWORDS];
	logic [3:0]  mdl_row [NLINES];
	bit          mdl_valid [NLINES];
	logic [15:0] mdl_age [NLINES];
	bit          mdl_dirty [NLINES];
	logic [15:0] mdl_mem [NMEM];

	cache_rsp_t  rsp_queue[$];
	int          fail_cnt = 0;
	bit          calm = 1'b0;

	assoc_line_cache_age_replace_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .addr(addr), .wdata(wdata),
		.out_valid(out_valid), .out_ready(out_ready),
		.rdata(rdata), .miss(miss)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] mem_word(int a);
		return (a < NMEM) ? mdl_mem[a] : 16'h0;
	endfunction

	function automatic void line_to_mem(int k);
		int a;
		for (int w = 0; w < NWORDS; w++) begin
			a = mdl_row[k] * NWORDS + w;
			if (a < NMEM) mdl_mem[a] = mdl_words[k][w];
		end
	endfunction

	function automatic int find_line(int row, output bit missed);
		int v;
		missed = 1'b0;
		for (int k = 0; k < NLINES; k++)
			if (mdl_valid[k] && mdl_row[k] == row) return k;
		v = -1;
		for (int k = 0; k < NLINES; k++)
			if (!mdl_valid[k] && v < 0) v = k;
		if (v < 0) begin
			v = 0;
			for (int k = 1; k < NLINES; k++)
				if (mdl_age[k] > mdl_age[v]) v = k;
			line_to_mem(v);
		end
		for (int w = 0; w < NWORDS; w++) mdl_words[v][w] = mem_word(row * NWORDS + w);
		mdl_row[v] = 4'(row);
		mdl_valid[v] = 1'b1;
		mdl_dirty[v] = 1'b0;
		mdl_age[v] = '0;
		missed = 1'b1;
		return v;
	endfunction

	function automatic cache_rsp_t cache_access(logic [2:0] c, logic [6:0] a, logic [15:0] d);
		cache_rsp_t r;
		int k;
		bit m;
		r = '0;
		case (c)
			alcar_pkg::OP_READ: begin
				k = find_line(a / NWORDS, m);
				r.rdata = mdl_words[k][a % NWORDS];
				r.miss = m;
				mdl_age[k] = '0;
			end
			alcar_pkg::OP_WRITE: begin
				k = find_line(a / NWORDS, m);
				r.miss = m;
				mdl_words[k][a % NWORDS] = d;
				mdl_age[k] = '0;
				mdl_dirty[k] = 1'b1;
			end
			alcar_pkg::OP_TICK:
				for (int i = 0; i < NLINES; i++)
					if (mdl_age[i] != AGE_TOP) mdl_age[i]++;
			alcar_pkg::OP_FLUSH:
				for (int i = 0; i < NLINES; i++)
					if (mdl_valid[i] && mdl_dirty[i]) begin
						line_to_mem(i);
						mdl_dirty[i] = 1'b0;
					end
			alcar_pkg::OP_MREAD: r.rdata = mem_word(a);
			alcar_pkg::OP_MLOAD: if (a < NMEM) mdl_mem[a] = d;
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(logic [2:0] c, logic [6:0] a, logic [15:0] d, bit known,
			cache_rsp_t want);
		cache_rsp_t got;
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		got = cache_access(c, a, d);
		if (known && got !== want) begin
			$display("%0t directed table: expected %h/%b, model %h/%b", $time,
				want.rdata, want.miss, got.rdata, got.miss);
			fail_cnt++;
		end
		rsp_queue.push_back(known ? want : got);
		in_valid <= 1'b1;
		op <= c;
		addr <= a;
		wdata <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (rsp_queue.size() == 0) begin
				$display("%0t unexpected item: actual %h/%b", $time, rdata, miss);
				fail_cnt++;
			end else begin
				if (rdata !== rsp_queue[0].rdata || miss !== rsp_queue[0].miss) begin
					$display("%0t mismatch: expected rdata %h miss %b, actual rdata %h miss %b",
						$time, rsp_queue[0].rdata, rsp_queue[0].miss, rdata, miss);
					fail_cnt++;
				end
				void'(rsp_queue.pop_front());
			end
		end
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
	end

	stim_row_t dir_tab[] = '{
		'{alcar_pkg::OP_READ,   7'd0,   16'h0000, 1, '{16'h0000, 1'b1}},
		'{alcar_pkg::OP_MREAD,  7'd127, 16'h0000, 1, '{16'h0000, 1'b0}},
		'{alcar_pkg::OP_MLOAD,  7'd127, 16'hFFFF, 1, '{16'h0000, 1'b0}},
		'{alcar_pkg::OP_MREAD,  7'd127, 16'h0000, 1, '{16'hFFFF, 1'b0}},
		'{alcar_pkg::OP_READ,   7'd127, 16'h0000, 1, '{16'hFFFF, 1'b1}},
		'{alcar_pkg::OP_WRITE,  7'd125, 16'hA5A5, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_WRITE,  7'd127, 16'h5A5A, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_MLOAD,  7'd1,   16'h1234, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_READ,   7'd1,   16'h0000, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_WRITE,  7'd20,  16'h0001, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_TICK,   7'd0,   16'h0000, 1, '{16'h0000, 1'b0}},
		'{alcar_pkg::OP_WRITE,  7'd35,  16'h8000, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_WRITE,  7'd49,  16'h7FFF, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_TICK,   7'd0,   16'h0000, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_WRITE,  7'd55,  16'hBEEF, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_READ,   7'd0,   16'h0000, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_FLUSH,  7'd0,   16'h0000, 1, '{16'h0000, 1'b0}},
		'{alcar_pkg::OP_MREAD,  7'd55,  16'h0000, 0, '{16'h0, 1'b0}},
		'{alcar_pkg::OP_MREAD,  7'd125, 16'h0000, 0, '{16'h0, 1'b0}},
		'{OP_NONE6,             7'd3,   16'hFFFF, 1, '{16'h0000, 1'b0}},
		'{OP_NONE7,             7'd127, 16'hFFFF, 1, '{16'h0000, 1'b0}},
		'{alcar_pkg::OP_READ,   7'd77,  16'h0000, 0, '{16'h0, 1'b0}}
	};

	initial begin
		logic [2:0] c;
		logic [6:0] a;
		for (int k = 0; k < NLINES; k++) begin
			mdl_row[k] = '0; mdl_valid[k] = 0; mdl_age[k] = '0; mdl_dirty[k] = 0;
			for (int w = 0; w < NWORDS; w++) mdl_words[k][w] = '0;
		end
		for (int i = 0; i < NMEM; i++) mdl_mem[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i])
			send_item(dir_tab[i].op, dir_tab[i].addr, dir_tab[i].wdata, dir_tab[i].known,
				dir_tab[i].rsp);
		for (int i = 0; i < 2000; i++) begin
			calm = (i >= 800 && i < 1000);
			if (i == 1200) begin
				in_valid <= 1'b0;
				while (rsp_queue.size() != 0) @(posedge clk);
				repeat (200) @(posedge clk);
			end
			a = (i % 4 == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(69));
			case ($urandom_range(99))
				0, 1: c = 3'($urandom_range(7, 6));
				2, 3, 4, 5, 6, 7, 8, 9: c = alcar_pkg::OP_TICK;
				10, 11, 12, 13: c = alcar_pkg::OP_FLUSH;
				14, 15, 16, 17, 18, 19, 20, 21: c = alcar_pkg::OP_MREAD;
				22, 23, 24, 25, 26, 27, 28, 29: c = alcar_pkg::OP_MLOAD;
				default: c = $urandom_range(1) ? alcar_pkg::OP_WRITE : alcar_pkg::OP_READ;
			endcase
			send_item(c, a, 16'($urandom_range(16'hFFFF)), 1'b0, '0);
		end
		in_valid <= 1'b0;
		calm = 1'b1;
		while (rsp_queue.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_cnt == 0 && rsp_queue.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

/* sim.f */
rtl/alcar_pkg.sv
rtl/alcar_ram.sv
rtl/assoc_line_cache_age_replace_unit.sv
dv/tb_top.sv
